// ===== src/dac_pkg.sv =====
// ----------------------------------------------------------------------------
// dac_pkg: shared types and constants for the damped angle chaser
// Opcodes, register indexes, register reset values and field widths.
// ----------------------------------------------------------------------------
package dac_pkg;

  // Fixed field widths of the stream items
  localparam int unsigned AngleInW   = 20;
  localparam int unsigned StepInW    = 20;
  localparam int unsigned OpW        = 2;
  localparam int unsigned OutAngleW  = 20;

  // Configuration register widths
  localparam int unsigned RateW      = 16;
  localparam int unsigned ThreshW    = 19;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 19;

  // Q2.14 factors
  localparam int unsigned Q14Frac    = 14;
  localparam int unsigned Q14Half    = 8192;

  localparam int unsigned AngleBitsDefault = 20;

  localparam logic [RateW-1:0]   DampingRateReset     = 16'd4915;
  localparam logic [RateW-1:0]   OvershootScaleReset  = 16'd16384;
  localparam logic [ThreshW-1:0] FinishThresholdReset = 19'd167;

  typedef enum logic [OpW-1:0] {
    OpTick  = 2'd0,
    OpChase = 2'd1,
    OpLoad  = 2'd2
  } op_e;

  typedef enum logic [CfgIndexW-1:0] {
    RegDampingRate     = 2'd0,
    RegOvershootScale  = 2'd1,
    RegFinishThreshold = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [RateW-1:0]   damping_rate;
    logic [RateW-1:0]   overshoot_scale;
    logic [ThreshW-1:0] finish_threshold;
  } cfg_t;

endpackage

// ===== src/dac_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dac_cfg_regs: configuration register file
// Damping rate, overshoot scale and finish threshold, written by index.
// ----------------------------------------------------------------------------
module dac_cfg_regs import dac_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegDampingRate:     cfg_d.damping_rate     = cfg_data_i[RateW-1:0];
        RegOvershootScale:  cfg_d.overshoot_scale  = cfg_data_i[RateW-1:0];
        RegFinishThreshold: cfg_d.finish_threshold = cfg_data_i[ThreshW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.damping_rate     <= DampingRateReset;
      cfg_q.overshoot_scale  <= OvershootScaleReset;
      cfg_q.finish_threshold <= FinishThresholdReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/dac_tick.sv =====
// ----------------------------------------------------------------------------
// dac_tick: one chase tick
// Advances the needle by the step, tests for overshoot, damps and reverses
// the step, and snaps to the goal once the step is small enough.
// ----------------------------------------------------------------------------
module dac_tick import dac_pkg::*; #(
  parameter int unsigned AngleBits = AngleBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  logic [AngleBits-1:0]        needle_i,
  input  logic [AngleBits-1:0]        goal_i,
  input  logic signed [AngleBits-1:0] step_i,
  output logic [AngleBits-1:0]        needle_o,
  output logic signed [AngleBits-1:0] step_o,
  output logic                        active_o
);

  localparam int unsigned MagW  = AngleBits - 1;
  localparam int unsigned ProdW = MagW + RateW;
  localparam int unsigned RndW  = ProdW + 1 - Q14Frac;
  localparam int unsigned CmpW  = (MagW > ThreshW) ? MagW : ThreshW;

  localparam logic [AngleBits-1:0] HalfTurn    = {1'b1, {(AngleBits-1){1'b0}}};
  localparam logic [RndW-1:0]      QuarterWide = RndW'(1) << (AngleBits - 2);

  logic [AngleBits-1:0]        needle_sum;
  logic signed [AngleBits:0]   delta, delta_neg;
  logic [AngleBits-1:0]        adist, gap;
  logic                        far_way, delta_pos, step_pos, step_neg, reverse;
  logic signed [AngleBits-1:0] step_neg_val;
  logic [MagW-1:0]             smag;
  logic [ProdW-1:0]            prod_scale, prod_damp;
  logic [ProdW:0]              damp_rnd;
  logic [RndW-1:0]             damp_mag;
  logic [MagW-1:0]             sat_mag;
  logic signed [AngleBits-1:0] sat_ext, step_rev, step_t, step_t_neg;
  logic                        overshoot;
  logic [MagW-1:0]             mag_t;
  logic                        finish;

  assign needle_sum = needle_i + step_i;

  assign delta     = $signed({1'b0, goal_i}) - $signed({1'b0, needle_sum});
  assign delta_neg = -delta;
  assign adist     = delta[AngleBits] ? delta_neg[AngleBits-1:0] : delta[AngleBits-1:0];
  assign far_way   = adist > HalfTurn;
  // long way round: the gap is the complement of the distance
  assign gap       = far_way ? (AngleBits'(0) - adist) : adist;

  assign delta_pos = !delta[AngleBits] && (delta != '0);
  assign step_neg  = step_i[AngleBits-1];
  assign step_pos  = !step_neg && (step_i != '0);

  always_comb begin
    priority if (far_way) begin
      reverse = delta_pos ? step_pos : step_neg;
    end else begin
      reverse = delta_pos ? step_neg : step_pos;
    end
  end

  assign step_neg_val = -step_i;
  assign smag = step_neg ? step_neg_val[MagW-1:0] : step_i[MagW-1:0];

  assign prod_scale = ProdW'(smag) * ProdW'(cfg_i.overshoot_scale);
  assign prod_damp  = ProdW'(smag) * ProdW'(cfg_i.damping_rate);

  assign overshoot = {1'b0, gap, {Q14Frac{1'b0}}} > prod_scale;

  // round half up, then saturate to a quarter turn
  assign damp_rnd = {1'b0, prod_damp} + (ProdW + 1)'(Q14Half);
  assign damp_mag = damp_rnd[ProdW:Q14Frac];
  assign sat_mag  = (damp_mag > QuarterWide) ? QuarterWide[MagW-1:0] : damp_mag[MagW-1:0];
  assign sat_ext  = $signed(AngleBits'(sat_mag));
  assign step_rev = step_pos ? -sat_ext : sat_ext;

  assign step_t     = (reverse && overshoot) ? step_rev : step_i;
  assign step_t_neg = -step_t;
  assign mag_t      = step_t[AngleBits-1] ? step_t_neg[MagW-1:0] : step_t[MagW-1:0];
  assign finish     = CmpW'(mag_t) < CmpW'(cfg_i.finish_threshold);

  assign needle_o = finish ? goal_i : needle_sum;
  assign step_o   = finish ? '0 : step_t;
  assign active_o = !finish;

  localparam logic signed [AngleBits-1:0] QuarterS = AngleBits'(1) << (AngleBits - 2);

  // a reversed step never leaves the quarter-turn band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_rev <= QuarterS) && (step_rev >= -QuarterS))
    else $error("reversed step outside quarter turn");

  // a reversal always flips the sign of a non-zero step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reverse && overshoot && step_rev != '0) |->
      (step_rev[AngleBits-1] != step_i[AngleBits-1]))
    else $error("reversal kept the step sign");

  // a finished tick lands exactly on the goal
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> (needle_o == goal_i) && (step_o == '0))
    else $error("finish did not snap to goal");

endmodule

// ===== src/damped_angle_chaser.sv =====
// ----------------------------------------------------------------------------
// damped_angle_chaser: needle angle chaser with damped overshoot
// Input register, tick logic with chase state, and result register.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the output is not stalled and returns
// one result item for each; an item passes the input register and then the
// result register. The rate is set by the state loop: needle add, distance, the
// two step multiplies and compares, and the finish test are combinational from
// the state registers back to themselves. Op tick advances an active chase, op
// chase starts a chase with goal and clamped step, op load sets the needle;
// op 3 leaves the state alone. Angles are ANGLE_BITS wide (full turn
// 2^ANGLE_BITS); current_angle reports the low 20 bits. The user must write
// registers only while no item is in flight; the block does not enforce this.
module damped_angle_chaser import dac_pkg::*; #(
  parameter int unsigned ANGLE_BITS = AngleBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,   // [19:0] angle_in, [39:20] step_in
  input  logic [OpW-1:0]       s_axis_tuser,   // [1:0] op
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata,   // [19:0] current_angle, [20] chasing
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned ClampW  = ((ANGLE_BITS > StepInW) ? ANGLE_BITS : StepInW) + 1;
  localparam int unsigned OutExtW = (ANGLE_BITS > OutAngleW) ? ANGLE_BITS : OutAngleW;
  localparam logic signed [ClampW-1:0] QuarterC = ClampW'(1) << (ANGLE_BITS - 2);

  cfg_t cfg;

  dac_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  // input register
  logic                      in_valid_q;
  op_e                       in_op_q;
  logic [AngleInW-1:0]       in_angle_q;
  logic signed [StepInW-1:0] in_step_q;
  logic                      adv;

  assign adv           = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q    <= op_e'(s_axis_tuser);
      in_angle_q <= s_axis_tdata[19:0];
      in_step_q  <= s_axis_tdata[39:20];
    end
  end

  // chase state
  logic [ANGLE_BITS-1:0]        needle_q, needle_d, goal_q, goal_d;
  logic signed [ANGLE_BITS-1:0] step_q, step_d;
  logic                         active_q, active_d;

  logic [ANGLE_BITS-1:0]        tick_needle;
  logic signed [ANGLE_BITS-1:0] tick_step;
  logic                         tick_active;

  dac_tick #(
    .AngleBits (ANGLE_BITS)
  ) u_tick (
    .clk_i,
    .rst_ni,
    .cfg_i    (cfg),
    .needle_i (needle_q),
    .goal_i   (goal_q),
    .step_i   (step_q),
    .needle_o (tick_needle),
    .step_o   (tick_step),
    .active_o (tick_active)
  );

  logic signed [ClampW-1:0] step_wide, step_clamped;

  assign step_wide    = ClampW'(in_step_q);
  assign step_clamped = (step_wide > QuarterC)  ? QuarterC  :
                        (step_wide < -QuarterC) ? -QuarterC : step_wide;

  always_comb begin
    needle_d = needle_q;
    goal_d   = goal_q;
    step_d   = step_q;
    active_d = active_q;
    if (adv) begin
      unique case (in_op_q)
        OpTick: begin
          if (active_q) begin
            needle_d = tick_needle;
            step_d   = tick_step;
            active_d = tick_active;
          end
        end
        OpChase: begin
          goal_d   = ANGLE_BITS'(in_angle_q);
          step_d   = step_clamped[ANGLE_BITS-1:0];
          active_d = 1'b1;
        end
        OpLoad: needle_d = ANGLE_BITS'(in_angle_q);
        default: ;  // unused op, state kept
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      goal_q   <= '0;
      step_q   <= '0;
      active_q <= 1'b0;
    end else begin
      needle_q <= needle_d;
      goal_q   <= goal_d;
      step_q   <= step_d;
      active_q <= active_d;
    end
  end

  // result register
  logic [OutExtW-1:0]   needle_ext_d, needle_ext_q;
  logic                 out_valid_q;
  logic [OutAngleW-1:0] out_angle_q;
  logic                 out_chasing_q;

  assign needle_ext_d = OutExtW'(needle_d);
  assign needle_ext_q = OutExtW'(needle_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_angle_q   <= needle_ext_d[OutAngleW-1:0];
      out_chasing_q <= active_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_chasing_q, out_angle_q};

  // idle chase always has a zero step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (step_q == '0))
    else $error("idle with non-zero step");

  // a held result always mirrors the current state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_chasing_q == active_q) &&
                    (out_angle_q == needle_ext_q[OutAngleW-1:0]))
    else $error("result out of step with state");

  // state moves only when an item is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(needle_q) && $stable(step_q) && $stable(active_q))
    else $error("state changed without an item");

  // an item leaving the input register always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("processed item lost");

endmodule
